>>> rtl/vbr_hdr_pkg.sv
package vbr_hdr_pkg;

    // Default for the byte limit of one frame
    localparam int DEFAULT_SCAN_LIMIT = 200;

    // Width of the byte counter (the limit stays below 256)
    localparam int POS_W = 8;

    // Window geometry
    localparam int WIN_LEN        = 26;
    localparam int FIRST_AT       = 4;
    localparam int FULL_AT        = WIN_LEN + FIRST_AT;
    localparam int XING_LEN       = 12;
    localparam int XING_FLAGS_OFS = 4;
    localparam int XING_COUNT_OFS = 8;
    localparam int VBRI_COUNT_OFS = 14;
    localparam int TAIL_LAST_IDX  = WIN_LEN - XING_LEN;

    // Header kinds
    localparam logic [1:0] KIND_NONE        = 2'd0;
    localparam logic [1:0] KIND_XING_COUNT  = 2'd1;
    localparam logic [1:0] KIND_XING_NOCNT  = 2'd2;
    localparam logic [1:0] KIND_VBRI        = 2'd3;

    // Marker characters
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_I_LO = 8'h69;
    localparam logic [7:0] CH_N_LO = 8'h6e;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_I_UP = 8'h49;
    localparam logic [7:0] CH_F_LO = 8'h66;
    localparam logic [7:0] CH_O_LO = 8'h6f;
    localparam logic [7:0] CH_V_UP = 8'h56;
    localparam logic [7:0] CH_B_UP = 8'h42;
    localparam logic [7:0] CH_R_UP = 8'h52;

    // Letter flags decoded once as a byte enters the chain
    typedef struct packed {
        logic x_up;
        logic i_lo;
        logic n_lo;
        logic g_lo;
        logic i_up;
        logic f_lo;
        logic o_lo;
        logic v_up;
        logic b_up;
        logic r_up;
    } letter_t;

    // Content of one window cell
    typedef struct packed {
        logic [7:0] data;
        letter_t    flags;
    } cell_t;

    // Decision of the marker comparators
    typedef struct packed {
        logic        hit;
        logic [1:0]  kind;
        logic [31:0] count;
    } match_t;

    function automatic cell_t cell_load(input logic [7:0] b);
        cell_t c;
        c.data       = b;
        c.flags.x_up = (b == CH_X_UP);
        c.flags.i_lo = (b == CH_I_LO);
        c.flags.n_lo = (b == CH_N_LO);
        c.flags.g_lo = (b == CH_G_LO);
        c.flags.i_up = (b == CH_I_UP);
        c.flags.f_lo = (b == CH_F_LO);
        c.flags.o_lo = (b == CH_O_LO);
        c.flags.v_up = (b == CH_V_UP);
        c.flags.b_up = (b == CH_B_UP);
        c.flags.r_up = (b == CH_R_UP);
        return c;
    endfunction

endpackage

>>> rtl/vbr_hdr_cell.sv
module vbr_hdr_cell
    import vbr_hdr_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  cell_t cell_in,
    output cell_t cell_q,
    output cell_t cell_d
);

    cell_t cell_reg;
    cell_t cell_next;

    // Take the neighbor's content on a shift, hold otherwise
    assign cell_next = shift ? cell_in : cell_reg;

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_q = cell_reg;
    assign cell_d = cell_next;

endmodule

>>> rtl/vbr_hdr_match.sv
module vbr_hdr_match
    import vbr_hdr_pkg::*;
(
    input  cell_t              win [WIN_LEN],
    input  logic [POS_W-1:0]   pos_next,
    input  logic               full_en,
    input  logic               tail_en,
    output match_t             result
);

    function automatic logic xing_at(input cell_t a, input cell_t b,
                                     input cell_t c, input cell_t d);
        return (a.flags.x_up & b.flags.i_lo & c.flags.n_lo & d.flags.g_lo) |
               (a.flags.i_up & b.flags.n_lo & c.flags.f_lo & d.flags.o_lo);
    endfunction

    function automatic logic vbri_at(input cell_t a, input cell_t b,
                                     input cell_t c, input cell_t d);
        return a.flags.v_up & b.flags.b_up & c.flags.r_up & d.flags.i_up;
    endfunction

    logic        tail_hit;
    logic        tail_flag;
    logic [31:0] tail_count;

    // Pick the earliest Xing/Info among the offsets short of a full window
    always_comb
    begin
        tail_hit   = 1'b0;
        tail_flag  = 1'b0;
        tail_count = '0;
        for (int i = TAIL_LAST_IDX; i >= 1; i--)
        begin
            if (({1'b0, pos_next} + 9'(i) >= 9'(FULL_AT)) &&
                xing_at(win[i], win[i+1], win[i+2], win[i+3]))
            begin
                tail_hit   = 1'b1;
                tail_flag  = win[i+XING_FLAGS_OFS+3].data[0];
                tail_count = {win[i+XING_COUNT_OFS].data,
                              win[i+XING_COUNT_OFS+1].data,
                              win[i+XING_COUNT_OFS+2].data,
                              win[i+XING_COUNT_OFS+3].data};
            end
        end
    end

    // Full test on the oldest cell first, then the tail scan
    always_comb
    begin
        result = '{hit: 1'b0, kind: KIND_NONE, count: 32'd0};
        if (full_en && xing_at(win[0], win[1], win[2], win[3]))
        begin
            result.hit = 1'b1;
            if (win[XING_FLAGS_OFS+3].data[0])
            begin
                result.kind  = KIND_XING_COUNT;
                result.count = {win[XING_COUNT_OFS].data,
                                win[XING_COUNT_OFS+1].data,
                                win[XING_COUNT_OFS+2].data,
                                win[XING_COUNT_OFS+3].data};
            end
            else
            begin
                result.kind = KIND_XING_NOCNT;
            end
        end
        else if (full_en && vbri_at(win[0], win[1], win[2], win[3]))
        begin
            result.hit   = 1'b1;
            result.kind  = KIND_VBRI;
            result.count = {win[VBRI_COUNT_OFS].data,
                            win[VBRI_COUNT_OFS+1].data,
                            win[VBRI_COUNT_OFS+2].data,
                            win[VBRI_COUNT_OFS+3].data};
        end
        else if (tail_en && tail_hit)
        begin
            result.hit = 1'b1;
            if (tail_flag)
            begin
                result.kind  = KIND_XING_COUNT;
                result.count = tail_count;
            end
            else
            begin
                result.kind = KIND_XING_NOCNT;
            end
        end
    end

endmodule

>>> rtl/vbr_header_frame_count_scan.sv
// VBR header frame count scan.
// Input stream: one frame byte per transfer on s_tdata[7:0], s_tlast set on
// the final byte of the frame. Only the first SCAN_LIMIT bytes are scanned;
// later bytes are taken and dropped, but their s_tlast still closes the frame.
// Output stream: one transfer per frame, issued after the s_tlast transfer,
// carrying the advertised frame count on m_tdata and the header kind on
// m_tuser (0 none, 1 Xing/Info with count, 2 Xing/Info without count, 3 VBRI).
// Throughput: one byte per cycle, back to back across frames, while the output
// is not stalled. The bytes move through a chain of 26 window cells; fixed
// comparators at the window taps decide each offset in the cycle its bytes are
// complete. The result is registered and valid in the cycle after the final
// byte is taken. A stalled receiver holds the result register; while a result
// waits, s_tready follows m_tready, so input bytes stall until it is taken.
// Reset (rst_n low, asynchronous) clears the byte counter, the decision and
// the output valid; the block is then at the start of a frame.
module vbr_header_frame_count_scan
    import vbr_hdr_pkg::*;
#(
    parameter int SCAN_LIMIT = DEFAULT_SCAN_LIMIT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] frame_count
    output logic [1:0]  m_tuser    // [1:0] header_kind
);

    logic             accept;
    logic             shift;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             decided_reg;
    logic [31:0]      held_count_reg;
    logic [1:0]       held_kind_reg;
    logic             full_en;
    logic             tail_en;
    match_t           match;

    logic             out_valid_reg;
    logic [31:0]      out_count_reg;
    logic [1:0]       out_kind_reg;

    cell_t            cell_q [WIN_LEN];
    cell_t            cell_d [WIN_LEN];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign shift    = accept && (pos_reg < POS_W'(SCAN_LIMIT));
    assign pos_next = shift ? pos_reg + 1'b1 : pos_reg;
    assign full_en  = shift && !decided_reg && (pos_next >= POS_W'(FULL_AT));
    assign tail_en  = accept && s_tlast && !decided_reg;

    // Window chain: the newest byte enters at the top cell
    genvar k;
    generate
        for (k = 0; k < WIN_LEN; k++)
        begin : g_cell
            cell_t feed;
            if (k == WIN_LEN - 1)
            begin : g_top
                assign feed = cell_load(s_tdata);
            end
            else
            begin : g_mid
                assign feed = cell_q[k+1];
            end
            vbr_hdr_cell u_cell (
                .clk     (clk),
                .shift   (shift),
                .cell_in (feed),
                .cell_q  (cell_q[k]),
                .cell_d  (cell_d[k])
            );
        end
    endgenerate

    vbr_hdr_match u_match (
        .win      (cell_d),
        .pos_next (pos_next),
        .full_en  (full_en),
        .tail_en  (tail_en),
        .result   (match)
    );

    // Track position and decision; restart at each frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            decided_reg    <= 1'b0;
            held_count_reg <= '0;
            held_kind_reg  <= KIND_NONE;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                pos_reg        <= '0;
                decided_reg    <= 1'b0;
                held_count_reg <= '0;
                held_kind_reg  <= KIND_NONE;
            end
            else
            begin
                pos_reg <= pos_next;
                if (match.hit)
                begin
                    decided_reg    <= 1'b1;
                    held_count_reg <= match.count;
                    held_kind_reg  <= match.kind;
                end
            end
        end
    end

    // Output valid: set on a frame end, clear once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && s_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload on a frame end
    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
        begin
            if (match.hit)
            begin
                out_count_reg <= match.count;
                out_kind_reg  <= match.kind;
            end
            else
            begin
                out_count_reg <= held_count_reg;
                out_kind_reg  <= held_kind_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;
    assign m_tuser  = out_kind_reg;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(SCAN_LIMIT))
        else $error("byte counter passed the scan limit");

    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> m_tvalid)
        else $error("frame end gave no result");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> (pos_reg == '0) && !decided_reg)
        else $error("scan state not cleared after frame end");

    a_decided_late: assert property (@(posedge clk) disable iff (!rst_n)
        decided_reg |-> pos_reg >= POS_W'(FULL_AT))
        else $error("decision before a full window");

    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_kind_reg == KIND_NONE || out_kind_reg == KIND_XING_NOCNT)
        |-> out_count_reg == 32'd0)
        else $error("nonzero count without a count field");
`endif

endmodule
